@@ hw/rtl/dcsm_pkg.sv @@
// Shared types, field layout and helper functions for the drive command safety mux.
// Used by every module under hw/rtl; depends on nothing.
package dcsm_pkg;

  localparam int AXIS_W     = 16;
  localparam int AGE_W      = 17;
  localparam int PERIOD_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int S_TDATA_W  = 88;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;

  localparam logic [PERIOD_W-1:0] STATUS_PERIOD_RST  = 16'd1000;
  localparam logic [PERIOD_W-1:0] COMMAND_PERIOD_RST = 16'd50;
  localparam logic [AGE_W-1:0]    AGE_MAX            = '1;
  localparam logic signed [AXIS_W-1:0] AUTO_STEER_RST = 16'sd22938;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN       = 16'sh8000;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX       = 16'sh7fff;

  // config register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_PERIOD  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_PERIOD = 1'b1;

  // send-now flag bits
  localparam int FLAG_STATUS = 0;
  localparam int FLAG_JOY    = 1;
  localparam int FLAG_AUTO   = 2;
  localparam logic [2:0] FLAGS_RST = 3'b011;

  typedef enum logic [1:0] {
    REQ_JOY  = 2'd0,
    REQ_CTRL = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     btn_stop;
    logic                     btn_cancel;
    logic                     btn_safety;
    logic                     btn_manual;
    logic                     btn_auto;
    logic signed [AXIS_W-1:0] axis_lx;
    logic signed [AXIS_W-1:0] axis_ly;
    logic signed [AXIS_W-1:0] axis_rx;
    logic signed [AXIS_W-1:0] ctrl_steer;
    logic signed [AXIS_W-1:0] ctrl_speed;
  } item_t;

  typedef struct packed {
    logic                     status_valid;
    logic                     mode_out;
    logic                     emergency_out;
    logic                     command_valid;
    logic signed [BYTE_W-1:0] steer_cmd;
    logic signed [BYTE_W-1:0] speed_cmd;
  } result_t;

  // floor(q * 127 / 32768); q*127 built as (q << 7) - q
  function automatic logic signed [BYTE_W-1:0] to_byte(input logic signed [AXIS_W-1:0] q);
    logic signed [23:0] qx;
    logic signed [23:0] p;
    qx = {{8{q[AXIS_W-1]}}, q};
    p  = (qx <<< 7) - qx;
    return p[22:15];
  endfunction

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

endpackage

@@ hw/rtl/dcsm_in_stage.sv @@
// Input register: takes one beat from the slave stream and unpacks its fields.
// Depends on dcsm_pkg.
module dcsm_in_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dcsm_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [dcsm_pkg::S_TUSER_W-1:0]     s_tuser,
  input  logic                               advance,
  output logic                               item_valid,
  output dcsm_pkg::item_t                    item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.req_type   <= s_tuser[1:0];
      item.btn_stop   <= s_tdata[0];
      item.btn_cancel <= s_tdata[1];
      item.btn_safety <= s_tdata[2];
      item.btn_manual <= s_tdata[3];
      item.btn_auto   <= s_tdata[4];
      item.axis_lx    <= s_tdata[20:5];
      item.axis_ly    <= s_tdata[36:21];
      item.axis_rx    <= s_tdata[52:37];
      item.ctrl_steer <= s_tdata[68:53];
      item.ctrl_speed <= s_tdata[84:69];
    end
  end

endmodule

@@ hw/rtl/dcsm_core.sv @@
// Mode, emergency latch, stored commands, send-age timers and config registers.
// One item is processed per fire; depends on dcsm_pkg.
module dcsm_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dcsm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dcsm_pkg::PERIOD_W-1:0]       cfg_wdata,
  input  logic                                fire,
  input  dcsm_pkg::item_t                     item,
  output logic                                res_valid,
  output dcsm_pkg::result_t                   res
);

  logic [dcsm_pkg::PERIOD_W-1:0] status_period;
  logic [dcsm_pkg::PERIOD_W-1:0] command_period;

  logic                                 auto_mode, auto_mode_next;
  logic                                 emergency_latch, emergency_latch_next;
  logic signed [dcsm_pkg::AXIS_W-1:0]   joy_steer, joy_steer_next;
  logic signed [dcsm_pkg::AXIS_W-1:0]   joy_speed, joy_speed_next;
  logic signed [dcsm_pkg::AXIS_W-1:0]   auto_steer, auto_steer_next;
  logic signed [dcsm_pkg::AXIS_W-1:0]   auto_speed, auto_speed_next;
  logic [dcsm_pkg::AGE_W-1:0]           status_age, status_age_next;
  logic [dcsm_pkg::AGE_W-1:0]           joy_age, joy_age_next;
  logic [dcsm_pkg::AGE_W-1:0]           auto_age, auto_age_next;
  logic [2:0]                           flags, flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_period  <= dcsm_pkg::STATUS_PERIOD_RST;
      command_period <= dcsm_pkg::COMMAND_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dcsm_pkg::CFG_STATUS_PERIOD:  status_period  <= cfg_wdata;
        dcsm_pkg::CFG_COMMAND_PERIOD: command_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    auto_mode_next       = auto_mode;
    emergency_latch_next = emergency_latch;
    joy_steer_next       = joy_steer;
    joy_speed_next       = joy_speed;
    auto_steer_next      = auto_steer;
    auto_speed_next      = auto_speed;
    status_age_next      = status_age;
    joy_age_next         = joy_age;
    auto_age_next        = auto_age;
    flags_next           = flags;
    res_valid            = 1'b0;
    res                  = '0;

    unique case (item.req_type)
      dcsm_pkg::REQ_JOY: begin
        if (item.btn_stop) begin
          auto_mode_next       = 1'b0;
          emergency_latch_next = 1'b1;
          flags_next[dcsm_pkg::FLAG_STATUS] = 1'b1;
        end else if (item.btn_cancel && item.axis_lx == '0) begin
          emergency_latch_next = 1'b0;
        end
        // latch blocks mode requests; manual wins over auto
        if (!emergency_latch_next) begin
          if (item.btn_manual) begin
            auto_mode_next = 1'b0;
          end else if (item.btn_auto) begin
            auto_mode_next = 1'b1;
          end
        end
        if (!auto_mode_next && !emergency_latch_next) begin
          if (item.btn_safety) begin
            joy_steer_next = (item.axis_rx == dcsm_pkg::AXIS_MIN) ? dcsm_pkg::AXIS_MAX
                                                                  : -item.axis_rx;
            joy_speed_next = item.axis_ly;
            flags_next[dcsm_pkg::FLAG_JOY] = 1'b1;
          end else begin
            joy_steer_next = '0;
            joy_speed_next = '0;
          end
        end
      end
      dcsm_pkg::REQ_CTRL: begin
        auto_steer_next = item.ctrl_steer;
        auto_speed_next = item.ctrl_speed;
        flags_next[dcsm_pkg::FLAG_AUTO] = 1'b1;
      end
      dcsm_pkg::REQ_TICK: begin
        status_age_next = dcsm_pkg::age_inc(status_age);
        joy_age_next    = dcsm_pkg::age_inc(joy_age);
        auto_age_next   = dcsm_pkg::age_inc(auto_age);
        if (flags[dcsm_pkg::FLAG_STATUS] || status_age_next > {1'b0, status_period}) begin
          res.status_valid = 1'b1;
          status_age_next  = '0;
          flags_next[dcsm_pkg::FLAG_STATUS] = 1'b0;
          // in emergency the status beat carries a zero command
          if (emergency_latch) begin
            res.command_valid = 1'b1;
            joy_age_next      = '0;
            flags_next[dcsm_pkg::FLAG_JOY] = 1'b0;
          end
        end
        if (!emergency_latch) begin
          if (!auto_mode) begin
            if (flags[dcsm_pkg::FLAG_JOY] || joy_age_next > {1'b0, command_period}) begin
              res.command_valid = 1'b1;
              res.steer_cmd     = dcsm_pkg::to_byte(joy_steer);
              res.speed_cmd     = dcsm_pkg::to_byte(joy_speed);
              joy_age_next      = '0;
              flags_next[dcsm_pkg::FLAG_JOY] = 1'b0;
            end
          end else begin
            if (flags[dcsm_pkg::FLAG_AUTO] || auto_age_next > {1'b0, command_period}) begin
              res.command_valid = 1'b1;
              res.steer_cmd     = dcsm_pkg::to_byte(auto_steer);
              res.speed_cmd     = dcsm_pkg::to_byte(auto_speed);
              auto_age_next     = '0;
              flags_next[dcsm_pkg::FLAG_AUTO] = 1'b0;
            end
          end
        end
        res.mode_out      = auto_mode;
        res.emergency_out = emergency_latch;
        res_valid         = res.status_valid || res.command_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode       <= 1'b0;
      emergency_latch <= 1'b0;
      joy_steer       <= '0;
      joy_speed       <= '0;
      auto_steer      <= dcsm_pkg::AUTO_STEER_RST;
      auto_speed      <= '0;
      status_age      <= '0;
      joy_age         <= '0;
      auto_age        <= '0;
      flags           <= dcsm_pkg::FLAGS_RST;
    end else if (fire) begin
      auto_mode       <= auto_mode_next;
      emergency_latch <= emergency_latch_next;
      joy_steer       <= joy_steer_next;
      joy_speed       <= joy_speed_next;
      auto_steer      <= auto_steer_next;
      auto_speed      <= auto_speed_next;
      status_age      <= status_age_next;
      joy_age         <= joy_age_next;
      auto_age        <= auto_age_next;
      flags           <= flags_next;
    end
  end

endmodule

@@ hw/rtl/dcsm_out_stage.sv @@
// Result register: holds one result beat for the master stream until it is taken.
// Depends on dcsm_pkg.
module dcsm_out_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  dcsm_pkg::result_t                  res,
  output logic                               out_free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dcsm_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic [dcsm_pkg::M_TUSER_W-1:0]     m_tuser
);

  dcsm_pkg::result_t res_q;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign m_tdata = {6'd0, res_q.speed_cmd, res_q.steer_cmd, res_q.emergency_out, res_q.mode_out};
  assign m_tuser = {res_q.command_valid, res_q.status_valid};

endmodule

@@ hw/rtl/drive_command_safety_mux.sv @@
// Drive command safety mux top level: input register, state core, result register.
// Depends on dcsm_pkg, dcsm_in_stage, dcsm_core, dcsm_out_stage.
//
// Takes one beat per clock: joystick events, controller events and 1 ms ticks, with
// s_tuser selecting the kind. An accepted beat is held in the input register and is
// processed once the result register is free; its result, if any, is loaded into the
// result register by the same fire that processes it. Only ticks produce result beats. The sustained
// rate is one beat per cycle; s_tready drops only while the result register holds a beat
// that the master side has not taken, and that stall also holds the input register.
// Configuration writes (cfg_we) land at once and belong in idle time.
module drive_command_safety_mux (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dcsm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dcsm_pkg::PERIOD_W-1:0]      cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // btn_stop, btn_cancel, btn_safety, btn_manual, btn_auto, axis_lx, axis_ly,
  // axis_rx, ctrl_steer, ctrl_speed, zero pad
  input  logic [dcsm_pkg::S_TDATA_W-1:0]     s_tdata,
  // req_type
  input  logic [dcsm_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // mode_out, emergency_out, steer_cmd, speed_cmd, zero pad
  output logic [dcsm_pkg::M_TDATA_W-1:0]     m_tdata,
  // status_valid, command_valid
  output logic [dcsm_pkg::M_TUSER_W-1:0]     m_tuser
);

  logic              item_valid;
  dcsm_pkg::item_t   item;
  logic              out_free;
  logic              fire;
  logic              res_valid;
  dcsm_pkg::result_t res;

  assign fire = item_valid && out_free;

  dcsm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  dcsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  dcsm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ hw/rtl/dcsm_checker.sv @@
// Port-level checker for drive_command_safety_mux, attached by bind.
// Depends on dcsm_pkg and the top level's ports.
module dcsm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [dcsm_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic [dcsm_pkg::M_TUSER_W-1:0]     m_tuser
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // every beat carries status or a command
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != '0)
    else $error("empty result beat");

  // no command: command bytes are zero
  a_nocmd_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[17:2] == '0)
    else $error("command bytes set without command_valid");

  // emergency forces manual mode and a zero command
  a_emerg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0] && m_tdata[17:2] == '0)
    else $error("emergency beat with auto mode or nonzero command");

endmodule

bind drive_command_safety_mux dcsm_checker u_dcsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ verif/drive_command_safety_mux_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for drive_command_safety_mux: directed table, random phases, then a directed run.
// Depends on dcsm_pkg and the drive_command_safety_mux RTL; results are checked by a local model.
module drive_command_safety_mux_tb;

  localparam logic [1:0]  REQ_RSVD     = 2'd3;  // unused kind, ignored by the block
  localparam logic [16:0] AGE_TOP      = 17'h1ffff;
  localparam int          QUIET_LIMIT  = 20000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 4;

  // button masks for the directed table
  localparam logic [4:0] B_STOP   = 5'b00001;
  localparam logic [4:0] B_CANCEL = 5'b00010;
  localparam logic [4:0] B_SAFETY = 5'b00100;
  localparam logic [4:0] B_MANUAL = 5'b01000;
  localparam logic [4:0] B_AUTO   = 5'b10000;

  typedef struct packed {
    logic                               status_valid;
    logic                               mode_out;
    logic                               emergency_out;
    logic                               command_valid;
    logic signed [dcsm_pkg::BYTE_W-1:0] steer_cmd;
    logic signed [dcsm_pkg::BYTE_W-1:0] speed_cmd;
  } drive_rep_t;

  typedef struct {
    dcsm_pkg::item_t it;
    bit              typed;
    drive_rep_t      want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [dcsm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [dcsm_pkg::PERIOD_W-1:0]   cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [dcsm_pkg::S_TDATA_W-1:0]  s_tdata = '0;
  logic [dcsm_pkg::S_TUSER_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [dcsm_pkg::M_TDATA_W-1:0]  m_tdata;
  logic [dcsm_pkg::M_TUSER_W-1:0]  m_tuser;

  drive_command_safety_mux dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  // local copy of the mux state
  logic                               mode_auto, estop;
  logic signed [dcsm_pkg::AXIS_W-1:0] j_steer, j_speed, a_steer, a_speed;
  logic [dcsm_pkg::AGE_W-1:0]         age_status, age_joy, age_auto;
  logic                               pend_status, pend_joy, pend_auto;
  logic [dcsm_pkg::PERIOD_W-1:0]      per_status, per_cmd;

  drive_rep_t report_q[$];
  dir_row_t   dir_tab[$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int n_items = 0, n_reports = 0, n_status = 0, n_cmds = 0, n_estop = 0, n_in_stalls = 0;

  function automatic logic signed [dcsm_pkg::BYTE_W-1:0] q15_to_byte(
      input logic signed [dcsm_pkg::AXIS_W-1:0] q);
    logic signed [31:0] prod;
    logic signed [31:0] shifted;
    prod = q * 32'sd127;
    shifted = prod >>> 15;
    return shifted[dcsm_pkg::BYTE_W-1:0];
  endfunction

  function automatic logic [dcsm_pkg::AGE_W-1:0] bump(input logic [dcsm_pkg::AGE_W-1:0] a);
    return (a == AGE_TOP) ? a : a + 1'b1;
  endfunction

  function automatic void mux_reset();
    mode_auto = 1'b0;
    estop = 1'b0;
    j_steer = '0;
    j_speed = '0;
    a_steer = dcsm_pkg::AUTO_STEER_RST;
    a_speed = '0;
    age_status = '0;
    age_joy = '0;
    age_auto = '0;
    pend_status = 1'b1;
    pend_joy = 1'b1;
    pend_auto = 1'b0;
    per_status = dcsm_pkg::STATUS_PERIOD_RST;
    per_cmd = dcsm_pkg::COMMAND_PERIOD_RST;
  endfunction

  // Advance the local state by one item; returns 1 when a report beat is due.
  function automatic bit next_drive_report(input dcsm_pkg::item_t it, output drive_rep_t rep);
    rep = '0;
    case (it.req_type)
      dcsm_pkg::REQ_JOY: begin
        if (it.btn_stop) begin
          mode_auto = 1'b0;
          estop = 1'b1;
          pend_status = 1'b1;
        end else if (it.btn_cancel && it.axis_lx == 0) begin
          estop = 1'b0;
        end
        if (!estop) begin
          if (it.btn_manual) mode_auto = 1'b0;
          else if (it.btn_auto) mode_auto = 1'b1;
        end
        if (!mode_auto && !estop) begin
          if (it.btn_safety) begin
            j_steer = (it.axis_rx == dcsm_pkg::AXIS_MIN) ? dcsm_pkg::AXIS_MAX : -it.axis_rx;
            j_speed = it.axis_ly;
            pend_joy = 1'b1;
          end else begin
            j_steer = '0;
            j_speed = '0;
          end
        end
        return 1'b0;
      end
      dcsm_pkg::REQ_CTRL: begin
        a_steer = it.ctrl_steer;
        a_speed = it.ctrl_speed;
        pend_auto = 1'b1;
        return 1'b0;
      end
      dcsm_pkg::REQ_TICK: begin
        age_status = bump(age_status);
        age_joy = bump(age_joy);
        age_auto = bump(age_auto);
        if (pend_status || age_status > per_status) begin
          rep.status_valid = 1'b1;
          age_status = '0;
          pend_status = 1'b0;
          // latched stop: zero command rides along with the status
          if (estop) begin
            rep.command_valid = 1'b1;
            age_joy = '0;
            pend_joy = 1'b0;
          end
        end
        if (!estop && !mode_auto && (pend_joy || age_joy > per_cmd)) begin
          rep.command_valid = 1'b1;
          rep.steer_cmd = q15_to_byte(j_steer);
          rep.speed_cmd = q15_to_byte(j_speed);
          age_joy = '0;
          pend_joy = 1'b0;
        end else if (!estop && mode_auto && (pend_auto || age_auto > per_cmd)) begin
          rep.command_valid = 1'b1;
          rep.steer_cmd = q15_to_byte(a_steer);
          rep.speed_cmd = q15_to_byte(a_speed);
          age_auto = '0;
          pend_auto = 1'b0;
        end
        rep.mode_out = mode_auto;
        rep.emergency_out = estop;
        return rep.status_valid || rep.command_valid;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic dcsm_pkg::item_t mk(input logic [1:0] kind, input logic [4:0] btns,
                                         input int lx, input int ly, input int rx,
                                         input int cs, input int cp);
    dcsm_pkg::item_t it;
    it.req_type = kind;
    {it.btn_auto, it.btn_manual, it.btn_safety, it.btn_cancel, it.btn_stop} = btns;
    it.axis_lx = lx[15:0];
    it.axis_ly = ly[15:0];
    it.axis_rx = rx[15:0];
    it.ctrl_steer = cs[15:0];
    it.ctrl_speed = cp[15:0];
    return it;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic dcsm_pkg::item_t rand_item();
    dcsm_pkg::item_t it;
    int sel;
    it = mk(dcsm_pkg::REQ_TICK, 5'($urandom_range(0, 31)), 0, 0, 0, 0, 0);
    it.axis_lx = rand_axis();
    it.axis_ly = rand_axis();
    it.axis_rx = rand_axis();
    it.ctrl_steer = rand_axis();
    it.ctrl_speed = rand_axis();
    sel = $urandom_range(0, 99);
    if (sel < 45) it.req_type = dcsm_pkg::REQ_TICK;
    else if (sel < 82) it.req_type = dcsm_pkg::REQ_JOY;
    else if (sel < 96) it.req_type = dcsm_pkg::REQ_CTRL;
    else it.req_type = REQ_RSVD;
    if (it.req_type == dcsm_pkg::REQ_JOY) begin
      it.btn_stop = ($urandom_range(0, 99) < 6);
      it.btn_cancel = ($urandom_range(0, 99) < 30);
      if (it.btn_cancel && $urandom_range(0, 9) < 6) it.axis_lx = '0;
      it.btn_safety = ($urandom_range(0, 99) < 70);
      it.btn_manual = ($urandom_range(0, 99) < 15);
      it.btn_auto = ($urandom_range(0, 99) < 20);
    end
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input dcsm_pkg::item_t it, input bit typed, input drive_rep_t want);
    drive_rep_t rep;
    bit due;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.req_type;
    s_tdata <= {3'b000, it.ctrl_speed, it.ctrl_steer, it.axis_rx, it.axis_ly, it.axis_lx,
                it.btn_auto, it.btn_manual, it.btn_safety, it.btn_cancel, it.btn_stop};
    do @(posedge clk); while (!s_tready);
    n_items++;
    due = next_drive_report(it, rep);
    if (typed) report_q.push_back(want);
    else if (due) report_q.push_back(rep);
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_item(rand_item(), 1'b0, '0);
  endtask

  // Let the pipeline empty; ticks that report nothing can still be in flight.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_periods(input logic [dcsm_pkg::PERIOD_W-1:0] st,
                             input logic [dcsm_pkg::PERIOD_W-1:0] cmd);
    cfg_we <= 1'b1;
    cfg_addr <= dcsm_pkg::CFG_STATUS_PERIOD;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_addr <= dcsm_pkg::CFG_COMMAND_PERIOD;
    cfg_wdata <= cmd;
    @(posedge clk);
    cfg_we <= 1'b0;
    per_status = st;
    per_cmd = cmd;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // output side: random stalls plus a single long hold-off
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    drive_rep_t want;
    logic signed [dcsm_pkg::BYTE_W-1:0] got_steer, got_speed;
    if (!rst && s_tvalid && !s_tready) n_in_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      n_reports++;
      n_status += int'(m_tuser[0]);
      n_cmds += int'(m_tuser[1]);
      n_estop += int'(m_tdata[1]);
      if (report_q.size() == 0) begin
        $error("report beat with nothing expected: tuser %b tdata %h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = report_q.pop_front();
        got_steer = m_tdata[9:2];
        got_speed = m_tdata[17:10];
        check_field("status_valid", int'(want.status_valid), int'(m_tuser[0]));
        check_field("command_valid", int'(want.command_valid), int'(m_tuser[1]));
        check_field("mode_out", int'(want.mode_out), int'(m_tdata[0]));
        check_field("emergency_out", int'(want.emergency_out), int'(m_tdata[1]));
        check_field("steer_cmd", int'(want.steer_cmd), int'(got_steer));
        check_field("speed_cmd", int'(want.speed_cmd), int'(got_speed));
      end
    end
  end

  // watchdog: too long without any beat moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    drive_rep_t none;
    none = '0;
    mux_reset();

    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b1, 1'b0, 1'b0, 1'b1, 8'sd0, 8'sd0}});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_SAFETY, 0, 32767, -32768, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b0, 1'b0, 1'b0, 1'b1, 8'sd126, 8'sd126}});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_SAFETY, 5, -32768, 32767, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b0, 1'b0, 1'b0, 1'b1, -8'sd127, -8'sd127}});
    // safety released: stored command zeroed, nothing sent
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, '0, 0, 1000, 1000, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_CTRL, '1, -1, -1, -1, -32768, 32767), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_AUTO, 0, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b0, 1'b1, 1'b0, 1'b1, -8'sd127, 8'sd126}});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_STOP | B_AUTO | B_SAFETY, 0, 77, 77, 0, 0),
                        1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b1, 1'b0, 1'b1, 1'b1, 8'sd0, 8'sd0}});
    // cancel ignored while the left stick is off center
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_CANCEL, 1, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_AUTO | B_SAFETY, 0, 300, 300, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_CANCEL | B_MANUAL | B_AUTO, 0, 0, 0, 0, 0),
                        1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_SAFETY, -32768, -1, 1, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(REQ_RSVD, '1, -1, -1, -1, -1, -1), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '1, -1, -1, -1, -1, -1), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_CTRL, B_STOP, 0, 0, 0, 1, -1), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_JOY, B_AUTO | B_CANCEL, 0, 0, 0, 0, 0), 1'b0, none});
    dir_tab.push_back('{mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // zero periods: every tick reports
    set_periods('0, '0);
    run_random(250, 0, 0);
    drain();

    set_periods(16'd1, 16'd1);
    run_random(350, 75, 0);
    drain();

    // long output hold-off while input keeps coming
    set_periods(16'd5, 16'd2);
    hold_req = 1;
    run_random(400, 0, 75);
    drain();

    repeat (5) begin
      set_periods(16'($urandom_range(0, 40)), 16'($urandom_range(0, 15)));
      run_random(110, 23, 23);
      drain();
    end

    // top periods: only the flags can trigger a send
    set_periods(16'hffff, 16'hffff);
    idle_pct = 0;
    stall_pct = 0;
    send_item(mk(dcsm_pkg::REQ_JOY, B_CANCEL | B_AUTO, 0, 0, 0, 0, 0), 1'b0, none);
    send_item(mk(dcsm_pkg::REQ_CTRL, '0, 0, 0, 0, 12345, -12345), 1'b0, none);
    send_item(mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none);
    send_item(mk(dcsm_pkg::REQ_JOY, B_MANUAL, 0, 0, 0, 0, 0), 1'b0, none);
    repeat (4) send_item(mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none);
    send_item(mk(dcsm_pkg::REQ_JOY, B_AUTO, 0, 0, 0, 0, 0), 1'b0, none);
    send_item(mk(dcsm_pkg::REQ_TICK, '0, 0, 0, 0, 0, 0), 1'b0, none);
    drain();

    $display("Run: %0d input beats over period settings 0 to 65535, %0d input stall cycles.",
             n_items, n_in_stalls);
    $display("Reports: %0d beats, %0d status, %0d command, %0d with stop latched.",
             n_reports, n_status, n_cmds, n_estop);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
